### hw/rtl/quantized_block_dequantizer_defines.svh
// Assertion macros used by the checker file of the block dequantizer.
`ifndef QUANTIZED_BLOCK_DEQUANTIZER_DEFINES_SVH
`define QUANTIZED_BLOCK_DEQUANTIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define QBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qbd check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define QBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qbd check failed");

`endif

### hw/rtl/qbd_pkg.sv
package qbd_pkg;

  // Block format codes held in the format register.
  typedef enum logic [1:0] {
    FMT_Q4_0 = 2'd0,
    FMT_Q4_1 = 2'd1,
    FMT_Q5_0 = 2'd2,
    FMT_Q8_0 = 2'd3
  } fmt_e;

  localparam int unsigned BlockElements = 32;
  localparam int unsigned PosWidth      = $clog2(BlockElements);
  localparam int unsigned InDataWidth   = 320;
  localparam int unsigned OutDataWidth  = 40;

  // Values are kept as integers in units of 2^-24, the smallest half step.
  localparam int unsigned ProdWidth = 19;
  localparam int unsigned PFixWidth = 48;
  localparam int unsigned MFixWidth = 40;
  localparam int unsigned SumWidth  = 50;
  localparam int unsigned MagWidth  = 49;
  localparam int unsigned LeadWidth = 6;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [7:0]  ExpBase  = 8'd103;

  // Per-element bookkeeping that rides along the pipeline.
  typedef struct packed {
    logic [PosWidth-1:0] pos;
    logic                last;
    logic                row_end;
  } meta_t;

  // Special-case result and zero sign, settled early and carried to the end.
  typedef struct packed {
    logic        spec_valid;
    logic [31:0] spec_bits;
    logic        zsign;
    meta_t       meta;
  } tail_t;

  // Significand of a half value, as an integer in units of 2^-24 before shift.
  function automatic logic [10:0] half_sig(input logic [15:0] h);
    half_sig = (h[14:10] != 5'd0) ? {1'b1, h[9:0]} : {1'b0, h[9:0]};
  endfunction

  // Left shift that turns the significand into units of 2^-24.
  function automatic logic [4:0] half_shift(input logic [15:0] h);
    half_shift = (h[14:10] != 5'd0) ? (h[14:10] - 5'd1) : 5'd0;
  endfunction

  // Bit position of the leading one; zero for a zero input.
  function automatic logic [LeadWidth-1:0] lead_one(input logic [MagWidth-1:0] v);
    logic [LeadWidth-1:0] pos;
    pos = '0;
    for (int i = 0; i < MagWidth; i++) begin
      if (v[i]) pos = LeadWidth'(i);
    end
    lead_one = pos;
  endfunction

endpackage

### hw/rtl/quantized_block_dequantizer.sv
// Quantized block dequantizer.
// The slave stream takes one 32-element quantized block per item: half scale,
// half offset, 32 fifth-bit flags and 32 code bytes in tdata, row end in tlast.
// The master stream gives one single-precision weight per item with its element
// index in tdata, tlast on element 31 and tuser on element 31 of a row's last
// block. The user must write the two-bit format register (Q4_0, Q4_1, Q5_0,
// Q8_0) through cfg_we_i only while the block is idle; no check enforces it.
// A block sits in an input buffer and, while the output is not stalled, issues
// one element per cycle into a six-register pipeline (code select, multiply,
// shift, add, magnitude, leading one search) ending in the output register,
// and results leave one per cycle under the same condition.
// The next block is accepted in the cycle its predecessor issues element 31.
// When the receiver deasserts tready while the output holds an item, the whole
// pipeline and the buffer hold, nothing is lost or repeated. Reset clears all
// valid bits, empties the buffer and sets the format to Q4_0.
module quantized_block_dequantizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // scale_bits, offset_bits, high_bits, codes_0, codes_1, codes_2, codes_3
  input  logic [qbd_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // value_bits, position, three zero bits
  output logic [qbd_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tuser_o
);
  import qbd_pkg::*;

  logic en;

  // Format register.
  fmt_e fmt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_Q4_0;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  // Input buffer holding one block, with the element issue counter.
  logic                buf_valid_q;
  logic [PosWidth-1:0] cnt_q;
  logic [15:0]         scale_q, offset_q;
  logic [31:0]         high_q;
  logic [15:0][7:0]    bytes_lo_q, bytes_hi_q;
  logic                row_last_q;
  logic                issue, issue_end, s_acc;

  assign issue     = en && buf_valid_q;
  assign issue_end = issue && (cnt_q == PosWidth'(BlockElements - 1));
  assign s_axis_tready_o = !buf_valid_q || issue_end;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (s_acc) begin
      buf_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (issue) begin
      cnt_q <= cnt_q + PosWidth'(1);
      if (issue_end) buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      scale_q    <= s_axis_tdata_i[15:0];
      offset_q   <= s_axis_tdata_i[31:16];
      high_q     <= s_axis_tdata_i[63:32];
      bytes_lo_q <= s_axis_tdata_i[191:64];
      bytes_hi_q <= s_axis_tdata_i[319:192];
      row_last_q <= s_axis_tlast_i;
    end
  end

  // Stage 1: pick the code of the issued element and form its signed value.
  logic [7:0]        byte_lo, byte_hi, q8_byte;
  logic [3:0]        nib;
  logic signed [8:0] q_d;
  meta_t             meta_d;

  always_comb begin
    byte_lo = bytes_lo_q[cnt_q[3:0]];
    byte_hi = bytes_hi_q[cnt_q[3:0]];
    q8_byte = cnt_q[4] ? byte_hi : byte_lo;
    nib     = cnt_q[4] ? byte_lo[7:4] : byte_lo[3:0];
    unique case (fmt_q)
      FMT_Q4_0: q_d = $signed({5'd0, nib}) - 9'sd8;
      FMT_Q4_1: q_d = $signed({5'd0, nib});
      FMT_Q5_0: q_d = $signed({4'd0, high_q[cnt_q], nib}) - 9'sd16;
      FMT_Q8_0: q_d = {q8_byte[7], q8_byte};
      default:  q_d = '0;
    endcase
    meta_d.pos     = cnt_q;
    meta_d.last    = (cnt_q == PosWidth'(BlockElements - 1));
    meta_d.row_end = meta_d.last && row_last_q;
  end

  logic              p1_valid_q;
  logic signed [8:0] p1_q_q;
  logic              p1_q41_q;
  logic [15:0]       p1_scale_q, p1_offset_q;
  meta_t             p1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= buf_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_q_q      <= q_d;
      p1_q41_q    <= (fmt_q == FMT_Q4_1);
      p1_scale_q  <= scale_q;
      p1_offset_q <= offset_q;
      p1_meta_q   <= meta_d;
    end
  end

  // Stage 2: integer product of scale significand and code magnitude,
  // plus the infinity, NaN and zero-sign cases.
  logic                 q_neg, q_zero, d_inf, d_nan, m_inf, m_nan;
  logic                 p_sign, p_inf, p_nan, r_nan, r_inf, r_isign;
  logic [7:0]           q_mag;
  logic [ProdWidth-1:0] prod_d;
  tail_t                tail2_d;

  always_comb begin
    q_neg   = p1_q_q[8];
    q_zero  = (p1_q_q == 9'sd0);
    q_mag   = q_neg ? 8'(-p1_q_q) : p1_q_q[7:0];
    prod_d  = ProdWidth'(half_sig(p1_scale_q)) * ProdWidth'(q_mag);
    d_inf   = (p1_scale_q[14:10] == 5'h1F) && (p1_scale_q[9:0] == 10'd0);
    d_nan   = (p1_scale_q[14:10] == 5'h1F) && (p1_scale_q[9:0] != 10'd0);
    m_inf   = p1_q41_q && (p1_offset_q[14:10] == 5'h1F) && (p1_offset_q[9:0] == 10'd0);
    m_nan   = p1_q41_q && (p1_offset_q[14:10] == 5'h1F) && (p1_offset_q[9:0] != 10'd0);
    p_sign  = p1_scale_q[15] ^ q_neg;
    p_nan   = d_nan || (d_inf && q_zero);
    p_inf   = d_inf && !q_zero;
    r_nan   = p_nan || m_nan || (p_inf && m_inf && (p_sign != p1_offset_q[15]));
    r_inf   = p_inf || m_inf;
    r_isign = p_inf ? p_sign : p1_offset_q[15];
    tail2_d.spec_valid = r_nan || r_inf;
    tail2_d.spec_bits  = r_nan ? CanonNan : {r_isign, 8'hFF, 23'd0};
    tail2_d.zsign      = p1_q41_q ? (p_sign && p1_offset_q[15]) : p_sign;
    tail2_d.meta       = p1_meta_q;
  end

  logic                 p2_valid_q;
  logic [ProdWidth-1:0] p2_prod_q;
  logic                 p2_psign_q, p2_q41_q;
  logic [4:0]           p2_dsh_q, p2_msh_q;
  logic [10:0]          p2_msig_q;
  logic                 p2_msign_q;
  tail_t                p2_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_prod_q  <= prod_d;
      p2_psign_q <= p_sign;
      p2_q41_q   <= p1_q41_q;
      p2_dsh_q   <= half_shift(p1_scale_q);
      p2_msh_q   <= half_shift(p1_offset_q);
      p2_msig_q  <= half_sig(p1_offset_q);
      p2_msign_q <= p1_offset_q[15];
      p2_tail_q  <= tail2_d;
    end
  end

  // Stage 3: scale both terms to units of 2^-24.
  logic                 p3_valid_q;
  logic [PFixWidth-1:0] p3_pfix_q;
  logic [MFixWidth-1:0] p3_mfix_q;
  logic                 p3_psign_q, p3_msign_q;
  tail_t                p3_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_pfix_q  <= PFixWidth'(p2_prod_q) << p2_dsh_q;
      p3_mfix_q  <= p2_q41_q ? (MFixWidth'(p2_msig_q) << p2_msh_q) : '0;
      p3_psign_q <= p2_psign_q;
      p3_msign_q <= p2_msign_q;
      p3_tail_q  <= p2_tail_q;
    end
  end

  // Stage 4: exact signed sum.
  logic signed [SumWidth-1:0] sp, sm;
  always_comb begin
    sp = p3_psign_q ? -$signed(SumWidth'(p3_pfix_q)) : $signed(SumWidth'(p3_pfix_q));
    sm = p3_msign_q ? -$signed(SumWidth'(p3_mfix_q)) : $signed(SumWidth'(p3_mfix_q));
  end

  logic                       p4_valid_q;
  logic signed [SumWidth-1:0] p4_sum_q;
  tail_t                      p4_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_sum_q  <= sp + sm;
      p4_tail_q <= p3_tail_q;
    end
  end

  // Stage 5: sign and magnitude.
  logic                p5_valid_q;
  logic [MagWidth-1:0] p5_mag_q;
  logic                p5_sign_q;
  tail_t               p5_tail_q;
  logic [SumWidth-1:0] abs_sum;

  assign abs_sum = p4_sum_q[SumWidth-1] ? SumWidth'(-p4_sum_q) : SumWidth'(p4_sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_valid_q <= 1'b0;
    end else if (en) begin
      p5_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_mag_q  <= abs_sum[MagWidth-1:0];
      p5_sign_q <= p4_sum_q[SumWidth-1];
      p5_tail_q <= p4_tail_q;
    end
  end

  // Stage 6: leading one search.
  logic                 p6_valid_q;
  logic [MagWidth-1:0]  p6_mag_q;
  logic [LeadWidth-1:0] p6_lead_q;
  logic                 p6_zero_q, p6_sign_q;
  tail_t                p6_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_valid_q <= 1'b0;
    end else if (en) begin
      p6_valid_q <= p5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_mag_q  <= p5_mag_q;
      p6_lead_q <= lead_one(p5_mag_q);
      p6_zero_q <= (p5_mag_q == '0);
      p6_sign_q <= p5_sign_q;
      p6_tail_q <= p5_tail_q;
    end
  end

  // Output stage: normalize, round to nearest even and pack.
  logic [MagWidth-1:0]  norm;
  logic [LeadWidth-1:0] lz;
  logic                 rnd_inc;
  logic [23:0]          mant_r;
  logic [7:0]           exp_r;
  logic [31:0]          value_d;

  always_comb begin
    lz      = LeadWidth'(MagWidth - 1) - p6_lead_q;
    norm    = p6_mag_q << lz;
    rnd_inc = norm[24] && ((|norm[23:0]) || norm[25]);
    mant_r  = {1'b0, norm[47:25]} + 24'(rnd_inc);
    exp_r   = ExpBase + 8'(p6_lead_q) + 8'(mant_r[23]);
    if (p6_tail_q.spec_valid) begin
      value_d = p6_tail_q.spec_bits;
    end else if (p6_zero_q) begin
      value_d = {p6_tail_q.zsign, 31'd0};
    end else begin
      value_d = {p6_sign_q, exp_r, mant_r[22:0]};
    end
  end

  logic        out_valid_q;
  logic [31:0] out_value_q;
  meta_t       out_meta_q;

  assign en = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q <= value_d;
      out_meta_q  <= p6_tail_q.meta;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_meta_q.pos, out_value_q};
  assign m_axis_tlast_o  = out_meta_q.last;
  assign m_axis_tuser_o  = out_meta_q.row_end;

endmodule

### hw/rtl/qbd_checker.sv
`include "quantized_block_dequantizer_defines.svh"

module qbd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [qbd_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  input logic                             m_axis_tlast_o,
  input logic                             m_axis_tuser_o
);
  import qbd_pkg::*;

  logic out_acc;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // A row end only falls on the last element of a block.
  `QBD_ASSERT_IMPL(a_row_end_on_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)

  // The last flag marks exactly element 31.
  `QBD_ASSERT_IMPL(a_last_pos, m_axis_tvalid_o, (m_axis_tdata_o[36:32] == 5'd31) == m_axis_tlast_o)

  // Within a block the elements come back to back in index order.
  `QBD_ASSERT_NEXT(a_pos_step, out_acc && !m_axis_tlast_o, m_axis_tvalid_o && (m_axis_tdata_o[36:32] == $past(m_axis_tdata_o[36:32]) + 5'd1))

  // A stalled item holds its payload.
  `QBD_ASSERT_NEXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind quantized_block_dequantizer qbd_checker u_qbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### verif/tb_quantized_block_dequantizer.sv
module tb_quantized_block_dequantizer;
  import qbd_pkg::*;

  localparam int WatchdogLimit = 20000;

  // One dequantized weight as the block should give it.
  typedef struct {
    logic [31:0]         value;
    logic [PosWidth-1:0] pos;
    logic                last;
    logic                row_end;
  } weight_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_wdata_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [InDataWidth-1:0]  s_axis_tdata_i = '0;
  logic                    s_axis_tlast_i = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata_o;
  logic                    m_axis_tlast_o;
  logic                    m_axis_tuser_o;

  quantized_block_dequantizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  fmt_e    cur_format = FMT_Q4_0;
  weight_t weights_due[$];
  int      fail_count = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;
  bit      in_fire, out_fire;
  weight_t seen;

  // Rounds a nonnegative integer in units of 2^-24 to single precision, to nearest even.
  function automatic logic [31:0] single_of(input bit s, input longint unsigned mag);
    longint unsigned mant, rem, halfw;
    int lead, sh;
    logic [7:0] ex;
    if (mag == 0) return {s, 31'b0};
    lead = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) lead = i;
    ex = 8'(lead + 103);
    if (lead <= 23) begin
      mant = mag << (23 - lead);
    end else begin
      sh = lead - 23;
      mant = mag >> sh;
      rem = mag & ((64'd1 << sh) - 1);
      halfw = 64'd1 << (sh - 1);
      if (rem > halfw || (rem == halfw && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        ex++;
      end
    end
    return {s, ex, mant[22:0]};
  endfunction

  // Splits a half value into sign, class and magnitude in units of 2^-24.
  function automatic void half_parts(input logic [15:0] h, output bit s, output bit inf,
                                     output bit nan, output longint unsigned mag);
    s = h[15];
    inf = (h[14:10] == 5'h1F) && (h[9:0] == 0);
    nan = (h[14:10] == 5'h1F) && (h[9:0] != 0);
    if (h[14:10] == 0) mag = h[9:0];
    else mag = longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
  endfunction

  // Works out the 32 weights of one block under the current format.
  function automatic void dequantize_block(input logic [15:0] sc, input logic [15:0] off,
                                           input logic [31:0] hi, input logic [255:0] codes,
                                           input logic row_last);
    bit ds, dinf, dnan, ms, minf, mnan, ps, pinf, pnan, zs;
    longint unsigned dmag, mmag, pm;
    longint sum;
    int q;
    logic [7:0] b;
    logic [3:0] nib;
    weight_t w;
    half_parts(sc, ds, dinf, dnan, dmag);
    half_parts(off, ms, minf, mnan, mmag);
    for (int k = 0; k < BlockElements; k++) begin
      b = codes[8 * (k % 16) +: 8];
      nib = (k < 16) ? b[3:0] : b[7:4];
      case (cur_format)
        FMT_Q4_0: q = int'(nib) - 8;
        FMT_Q4_1: q = int'(nib);
        FMT_Q5_0: q = int'({hi[k], nib}) - 16;
        default:  q = int'($signed(codes[8 * k +: 8]));
      endcase
      // Product of the scale and the code; infinity times zero is NaN.
      pnan = dnan || (dinf && q == 0);
      pinf = dinf && q != 0;
      ps = ds ^ (q < 0);
      pm = dmag * longint'(q < 0 ? -q : q);
      if (cur_format != FMT_Q4_1) begin
        if (pnan) w.value = CanonNan;
        else if (pinf) w.value = {ps, 8'hFF, 23'b0};
        else w.value = single_of(ps, pm);
      end else begin
        // Sum with the offset, exact in integers and rounded once.
        if (pnan || mnan || (pinf && minf && ps != ms)) w.value = CanonNan;
        else if (pinf) w.value = {ps, 8'hFF, 23'b0};
        else if (minf) w.value = {ms, 8'hFF, 23'b0};
        else begin
          sum = (ps ? -longint'(pm) : longint'(pm)) + (ms ? -longint'(mmag) : longint'(mmag));
          if (sum == 0) begin
            zs = (pm == 0 && mmag == 0) ? (ps & ms) : 1'b0;
            w.value = {zs, 31'b0};
          end else begin
            w.value = single_of(sum < 0, sum < 0 ? -sum : sum);
          end
        end
      end
      w.pos = PosWidth'(k);
      w.last = (k == 31);
      w.row_end = (k == 31) && row_last;
      weights_due.push_back(w);
    end
  endfunction

  // Offers one block and waits until it is taken.
  task automatic send_block(input logic [15:0] sc, input logic [15:0] off,
                            input logic [31:0] hi, input logic [255:0] codes,
                            input logic row_last);
    bit taken;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {codes, hi, off, sc};
    s_axis_tlast_i <= row_last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    dequantize_block(sc, off, hi, codes, row_last);
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every due weight arrive, then writes the format register.
  task automatic set_format(input fmt_e f);
    stop_sending();
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_format = f;
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(9))
      0: return 16'h0000 | 16'($urandom_range(1) << 15);
      1: return 16'h7C00 | 16'($urandom_range(1) << 15);
      2: return 16'h7C00 | 16'($urandom_range(1023, 1)) | 16'($urandom_range(1) << 15);
      3: return 16'($urandom_range(1023)) | 16'($urandom_range(1) << 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [255:0] pick_codes();
    logic [255:0] c;
    for (int i = 0; i < 8; i++) c[32 * i +: 32] = $urandom;
    return c;
  endfunction

  // Extremes of scale, offset and codes shared by the directed tests.
  task automatic directed_blocks();
    send_block(16'h3C00, 16'h0000, 32'h0000_0000, '0, 1'b0);
    send_block(16'h3C00, 16'h3C00, 32'hFFFF_FFFF, '1, 1'b1);
    send_block(16'h7BFF, 16'hFBFF, 32'hA5A5_5A5A, pick_codes(), 1'b0);
    send_block(16'h0001, 16'h8001, 32'h0F0F_F0F0, pick_codes(), 1'b1);
    send_block(16'h8000, 16'h8000, $urandom, pick_codes(), 1'b0);
    send_block(16'h7C00, 16'hFC00, $urandom, pick_codes(), 1'b0);
  endtask

  task automatic test_q4_0();
    set_format(FMT_Q4_0);
    directed_blocks();
    send_block(16'h7E00, 16'h1234, 32'h0, pick_codes(), 1'b1);
  endtask

  task automatic test_q4_1();
    set_format(FMT_Q4_1);
    directed_blocks();
    // Infinite product plus an opposite infinity, and finite plus NaN.
    send_block(16'hFC00, 16'h7C00, 32'h0, '1, 1'b1);
    send_block(16'h3555, 16'hFE01, 32'h0, pick_codes(), 1'b0);
    send_block(16'h03FF, 16'h83FF, 32'h0, pick_codes(), 1'b0);
  endtask

  task automatic test_q5_0();
    set_format(FMT_Q5_0);
    directed_blocks();
  endtask

  task automatic test_q8_0();
    set_format(FMT_Q8_0);
    directed_blocks();
    send_block(16'h3C00, 16'h0, 32'h0, {32{8'h80}}, 1'b1);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) set_format(fmt_e'($urandom_range(3)));
      send_block(pick_half(), pick_half(), $urandom, pick_codes(), 1'($urandom));
    end
  endtask

  // The receiver holds off while blocks keep coming, so the input stalls.
  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 8; i++)
      send_block(pick_half(), pick_half(), $urandom, pick_codes(), 1'($urandom));
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Sample both handshakes away from the clock edge.
  always @(negedge clk_i) begin
    in_fire = s_axis_tvalid_i && s_axis_tready_o;
    out_fire = m_axis_tvalid_o && m_axis_tready_i;
    seen.value = m_axis_tdata_o[31:0];
    seen.pos = m_axis_tdata_o[32 +: PosWidth];
    seen.last = m_axis_tlast_o;
    seen.row_end = m_axis_tuser_o;
  end

  // Compare each accepted weight with the oldest one due.
  always @(posedge clk_i) begin
    weight_t want;
    if (rst_ni && out_fire) begin
      if (weights_due.size() == 0) begin
        $error("weight with none due: value %h", seen.value);
        fail_count++;
      end else begin
        want = weights_due.pop_front();
        if (seen.value !== want.value) begin
          $error("value_bits: expected %h, got %h", want.value, seen.value);
          fail_count++;
        end
        if (seen.pos !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, seen.pos);
          fail_count++;
        end
        if (seen.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, seen.last);
          fail_count++;
        end
        if (seen.row_end !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, seen.row_end);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin
    if (in_fire || out_fire || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 21;
    snk_idle_pct = 83;
    test_q4_0();
    test_q4_1();
    test_q5_0();
    test_q8_0();
    test_random(170);
    src_idle_pct = 83;
    snk_idle_pct = 21;
    test_random(170);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(160);
    test_backpressure();
    stop_sending();
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && weights_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### quantized_block_dequantizer.f
+incdir+hw/rtl
hw/rtl/qbd_pkg.sv
hw/rtl/quantized_block_dequantizer.sv
hw/rtl/qbd_checker.sv
verif/tb_quantized_block_dequantizer.sv
